// File: rtl/snmp_kl_pkg.sv
// ----------------------------------------------------------------------------
// snmp_kl_pkg: shared types and constants for SNMP key localization
// Item structs, state encoding, MD5 constant and rotate tables.
// ----------------------------------------------------------------------------
`default_nettype none

package snmp_kl_pkg;

    localparam int MAX_PASSWORD  = 64;
    localparam int MAX_ENGINE_ID = 32;
    localparam int PW_CNT_W      = 8;
    localparam int ENG_CNT_W     = 6;
    localparam int PW_IDX_W      = $clog2(MAX_PASSWORD);
    localparam int ENG_IDX_W     = $clog2(MAX_ENGINE_ID);
    // 1048576 bytes = 16384 blocks of 64 bytes
    localparam int EXP_BLOCKS    = 16384;
    localparam int BLK_CNT_W     = 15;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last_byte;
        logic [1:0] status;
    } out_item_t;

    // Message block source selection
    typedef enum logic [2:0] {
        SRC_PASSWORD,   // cyclic password bytes
        SRC_PAD1,       // padding block for the 1 MiB message
        SRC_LOC,        // Ku | engine | Ku (+ padding if it fits)
        SRC_LOC_PAD     // second block of localization padding
    } blk_src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,        // load 64 message bytes, one per cycle
        ST_ROUND,       // 64 MD5 rounds, one per cycle
        ST_ADD,         // add working vars to chaining value
        ST_EMIT,        // present key bytes
        ST_ERROR        // present error result
    } state_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        logic [4:0] r;
        unique case ({i[5:4], i[1:0]})
            4'b0000: r = 5'd7;  4'b0001: r = 5'd12; 4'b0010: r = 5'd17; 4'b0011: r = 5'd22;
            4'b0100: r = 5'd5;  4'b0101: r = 5'd9;  4'b0110: r = 5'd14; 4'b0111: r = 5'd20;
            4'b1000: r = 5'd4;  4'b1001: r = 5'd11; 4'b1010: r = 5'd16; 4'b1011: r = 5'd23;
            4'b1100: r = 5'd6;  4'b1101: r = 5'd10; 4'b1110: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/snmp_password_key_localize.sv
// ----------------------------------------------------------------------------
// snmp_password_key_localize: SNMPv3 MD5 password to localized key
// Stores password and engine ID bytes, then runs one shared MD5 round unit
// over the expanded password and the localization message.
// ----------------------------------------------------------------------------
// The final engine ID item starts 16386 or 16387 blocks, each a 64-byte fill,
// 64 MD5 rounds and an add, paced by the one-round-per-cycle MD5 unit and
// byte-wide block fill. Then 16 key transfers, one per cycle when out_ready is
// high; an error item gives its single result the cycle after it is accepted.
// Reset clears counts, overflow flag and the sequencer; stores are not cleared.
`default_nettype none

module snmp_password_key_localize
    import snmp_kl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    // Byte stores
    logic [7:0] pw_mem  [MAX_PASSWORD];
    logic [7:0] eng_mem [MAX_ENGINE_ID];

    logic [PW_CNT_W-1:0]  pw_cnt_reg;
    logic [ENG_CNT_W-1:0] eng_cnt_reg;
    logic                 ovf_reg;

    state_t     state_reg, state_next;
    blk_src_t   src_reg, src_next;
    logic [5:0] cnt_reg, cnt_next;          // byte / round / emit index
    logic [BLK_CNT_W-1:0] blk_reg, blk_next;
    logic [PW_IDX_W-1:0]  pidx_reg, pidx_next;
    logic [1:0] err_reg, err_next;

    logic [31:0] h_reg [4];                 // chaining value
    logic [31:0] ku_reg [4];                // Ku
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] msg_reg [16];

    // Registered byte reads; the address is the next fill position
    logic [7:0] pw_rd_reg, eng_rd_reg, fill_byte;
    logic [ENG_IDX_W-1:0] eng_addr;
    logic [6:0] loc_n;                      // 32 + engine count
    logic [6:0] pos;                        // byte position inside loc message

    wire in_xfer  = in_valid && in_ready;
    wire out_xfer = out_valid && out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign loc_n     = 7'd32 + {1'b0, eng_cnt_reg};
    assign eng_addr  = ENG_IDX_W'(cnt_next - 6'd16);

    // Byte i of a 128-bit key held as four words, low byte of each word first
    function automatic logic [7:0] ku_byte(input logic [3:0] i, input logic [31:0] k0,
        input logic [31:0] k1, input logic [31:0] k2, input logic [31:0] k3);
        logic [31:0] w;
        case (i[3:2])
            2'd0: w = k0;
            2'd1: w = k1;
            2'd2: w = k2;
            default: w = k3;
        endcase
        return w[{i[1:0], 3'b000} +: 8];
    endfunction

    logic [9:0]  loc_bits;
    assign loc_bits  = {loc_n, 3'b000};

    always_comb
    begin
        pos       = {1'b0, cnt_reg};
        fill_byte = 8'h00;
        unique case (src_reg)
            SRC_PASSWORD: fill_byte = pw_rd_reg;
            SRC_PAD1:
            begin
                // 0x80, zeros, length 2^23 bits little endian
                if (cnt_reg == 6'd0)       fill_byte = 8'h80;
                else if (cnt_reg == 6'd58) fill_byte = 8'h80;
                else                       fill_byte = 8'h00;
            end
            SRC_LOC:
            begin
                if (pos < 7'd16)
                    fill_byte = ku_byte(cnt_reg[3:0], ku_reg[0], ku_reg[1], ku_reg[2], ku_reg[3]);
                else if (pos < 7'd16 + {1'b0, eng_cnt_reg})
                    fill_byte = eng_rd_reg;
                else if (pos < loc_n)
                    fill_byte = ku_byte(4'(pos - 7'd16 - {1'b0, eng_cnt_reg}),
                                        ku_reg[0], ku_reg[1], ku_reg[2], ku_reg[3]);
                else if (pos == loc_n)
                    fill_byte = 8'h80;
                else if (loc_n < 7'd56 && cnt_reg == 6'd56)
                    fill_byte = loc_bits[7:0];
                else if (loc_n < 7'd56 && cnt_reg == 6'd57)
                    fill_byte = {6'd0, loc_bits[9:8]};
                else
                    fill_byte = 8'h00;
            end
            default:
            begin
                // second block: 0x80 first only when message filled block one
                if (cnt_reg == 6'd0 && loc_n == 7'd64) fill_byte = 8'h80;
                else if (cnt_reg == 6'd56)            fill_byte = loc_bits[7:0];
                else if (cnt_reg == 6'd57)            fill_byte = {6'd0, loc_bits[9:8]};
                else                                  fill_byte = 8'h00;
            end
        endcase
    end

    // Shared MD5 round unit
    logic [31:0] f_val, m_val, t_val, rot_val;
    logic [3:0]  g_idx;
    logic [4:0]  r_amt;
    always_comb
    begin
        unique case (cnt_reg[5:4])
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = cnt_reg[3:0];
            end
            2'd1:
            begin
                f_val = (d_reg & b_reg) | (~d_reg & c_reg);
                g_idx = 4'({cnt_reg, 2'b00} + {2'b00, cnt_reg} + 8'd1);
            end
            2'd2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = 4'({1'b0, cnt_reg, 1'b0} + {2'b00, cnt_reg} + 8'd5);
            end
            default:
            begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = 4'({cnt_reg, 2'b00} + {1'b0, cnt_reg, 1'b0} + {2'b00, cnt_reg});
            end
        endcase
        m_val   = msg_reg[g_idx];
        r_amt   = md5_rot(cnt_reg);
        t_val   = a_reg + f_val + md5_k(cnt_reg) + m_val;
        rot_val = (t_val << r_amt) | (t_val >> (6'd32 - {1'b0, r_amt}));
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        cnt_next   = cnt_reg;
        blk_next   = blk_reg;
        pidx_next  = pidx_reg;
        err_next   = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_data.mode && in_data.last)
                begin
                    cnt_next  = '0;
                    pidx_next = '0;
                    blk_next  = '0;
                    src_next  = SRC_PASSWORD;
                    if (ovf_reg || eng_cnt_reg == ENG_CNT_W'(MAX_ENGINE_ID))
                    begin
                        err_next   = STATUS_OVERFLOW;
                        state_next = ST_ERROR;
                    end
                    else if (pw_cnt_reg == '0)
                    begin
                        err_next   = STATUS_EMPTY;
                        state_next = ST_ERROR;
                    end
                    else
                        state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (src_reg == SRC_PASSWORD)
                    pidx_next = ({1'b0, pidx_reg} + 8'd1 >= pw_cnt_reg) ? '0
                                : pidx_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_FILL;
                unique case (src_reg)
                    SRC_PASSWORD:
                    begin
                        blk_next = blk_reg + 1'b1;
                        if (blk_reg == BLK_CNT_W'(EXP_BLOCKS - 1))
                            src_next = SRC_PAD1;
                    end
                    SRC_PAD1: src_next = SRC_LOC;
                    SRC_LOC:
                        if (loc_n >= 7'd56) src_next = SRC_LOC_PAD;
                        else                state_next = ST_EMIT;
                    default: state_next = ST_EMIT;
                endcase
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 6'd15)
                        state_next = ST_IDLE;
                end
            end
            default:
                if (out_xfer) state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            src_reg     <= SRC_PASSWORD;
            cnt_reg     <= '0;
            blk_reg     <= '0;
            pidx_reg    <= '0;
            err_reg     <= STATUS_OK;
            pw_cnt_reg  <= '0;
            eng_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            cnt_reg   <= cnt_next;
            blk_reg   <= blk_next;
            pidx_reg  <= pidx_next;
            err_reg   <= err_next;
            if (in_xfer)
            begin
                if (!in_data.mode)
                begin
                    if (pw_cnt_reg < PW_CNT_W'(MAX_PASSWORD)) pw_cnt_reg <= pw_cnt_reg + 1'b1;
                    else                                       ovf_reg    <= 1'b1;
                end
                else if (eng_cnt_reg < ENG_CNT_W'(MAX_ENGINE_ID))
                    eng_cnt_reg <= eng_cnt_reg + 1'b1;
                else if (!in_data.last)
                    ovf_reg <= 1'b1;
            end
            // counts clear once the result has been handed over
            if ((state_reg == ST_EMIT && out_xfer && cnt_reg == 6'd15) ||
                (state_reg == ST_ERROR && out_xfer))
            begin
                pw_cnt_reg  <= '0;
                eng_cnt_reg <= '0;
                ovf_reg     <= 1'b0;
            end
        end
    end

    // Stores: written on load transfers, read one byte ahead of the fill
    always_ff @(posedge clk)
    begin
        if (in_xfer && !in_data.mode && pw_cnt_reg < PW_CNT_W'(MAX_PASSWORD))
            pw_mem[pw_cnt_reg[PW_IDX_W-1:0]] <= in_data.data_byte;
        if (in_xfer && in_data.mode && eng_cnt_reg < ENG_CNT_W'(MAX_ENGINE_ID))
            eng_mem[eng_cnt_reg[ENG_IDX_W-1:0]] <= in_data.data_byte;
        pw_rd_reg  <= pw_mem[pidx_next];
        eng_rd_reg <= eng_mem[eng_addr];
    end

    // Datapath: message block, working variables, chaining value
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            h_reg[0] <= 32'h67452301;
            h_reg[1] <= 32'hefcdab89;
            h_reg[2] <= 32'h98badcfe;
            h_reg[3] <= 32'h10325476;
        end
        if (state_reg == ST_FILL)
        begin
            msg_reg[cnt_reg[5:2]][{cnt_reg[1:0], 3'b000} +: 8] <= fill_byte;
            if (cnt_reg == 6'd63)
            begin
                a_reg <= h_reg[0];
                b_reg <= h_reg[1];
                c_reg <= h_reg[2];
                d_reg <= h_reg[3];
            end
        end
        if (state_reg == ST_ROUND)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot_val;
        end
        if (state_reg == ST_ADD)
        begin
            if (src_reg == SRC_PAD1)
            begin
                // Ku done; restart chaining for the localization hash
                ku_reg[0] <= h_reg[0] + a_reg;
                ku_reg[1] <= h_reg[1] + b_reg;
                ku_reg[2] <= h_reg[2] + c_reg;
                ku_reg[3] <= h_reg[3] + d_reg;
                h_reg[0]  <= 32'h67452301;
                h_reg[1]  <= 32'hefcdab89;
                h_reg[2]  <= 32'h98badcfe;
                h_reg[3]  <= 32'h10325476;
            end
            else
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
            end
        end
    end

    // Output
    assign out_valid = (state_reg == ST_EMIT) || (state_reg == ST_ERROR);
    always_comb
    begin
        if (state_reg == ST_ERROR)
        begin
            out_data.key_byte  = 8'h00;
            out_data.last_byte = 1'b1;
            out_data.status    = err_reg;
        end
        else
        begin
            out_data.key_byte  = ku_byte(cnt_reg[3:0], h_reg[0], h_reg[1], h_reg[2], h_reg[3]);
            out_data.last_byte = (cnt_reg[3:0] == 4'd15);
            out_data.status    = STATUS_OK;
        end
    end

    // Checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("input accepted while busy");
    a_out_only_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_EMIT || state_reg == ST_ERROR))
        else $error("output valid outside result phase");
    a_err_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ERROR |-> err_reg != STATUS_OK)
        else $error("error result without error status");
    a_pw_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> pw_cnt_reg != '0)
        else $error("hashing with empty password");

endmodule

`default_nettype wire
